FILE: rtl/core/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg: shared types and constants of the boxcar moving average
// Holds the sequencer state type and the fixed width of the window-length
// register.
// ----------------------------------------------------------------------------
package bma_pkg;

   // width of the window-length register, fixed by the register map
   localparam int WINDOW_LENGTH_WIDTH = 7;

   // reset value of the window-length register
   localparam logic [WINDOW_LENGTH_WIDTH-1:0] WINDOW_LENGTH_RESET = 7'd4;

   typedef enum logic [1:0] {
      BMA_IDLE,
      BMA_UPDATE,
      BMA_DIVIDE,
      BMA_DONE
   } bma_state_type;

endpackage

FILE: rtl/core/bma_if.sv
// ----------------------------------------------------------------------------
// bma_if: valid/ready channels of the boxcar moving average
// Sample request channel, average response channel and the register write
// channel.
// ----------------------------------------------------------------------------
interface bma_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           series_start;

   modport source (output valid, output sample, output series_start, input ready);
   modport sink   (input valid, input sample, input series_start, output ready);
endinterface

interface bma_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

interface bma_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [bma_pkg::WINDOW_LENGTH_WIDTH-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/bma_ram.sv
// ----------------------------------------------------------------------------
// bma_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/boxcar_moving_average_core.sv
// ----------------------------------------------------------------------------
// boxcar_moving_average_core: streaming boxcar moving average
// Delay line in RAM, exact running sum, fill count and a bit-serial divider.
// ----------------------------------------------------------------------------
// Each request item carries one signed sample and a series-start flag. The
// last WINDOW_MAX samples live in a circular delay line held in a RAM with a
// registered read. From the window_length-th sample of the current series
// on, every sample yields one response item: the exact sum of the last
// window_length samples divided by window_length, truncated toward zero. A
// window length of zero yields no responses; values above WINDOW_MAX act as
// WINDOW_MAX. Writing the register clears the sum and the fill count, so the
// next sample opens a new series; write it only while the block is idle.
// Sequence: an item is taken in the idle state, which issues the read of the
// sample leaving the window (with a zero window the item is dropped there);
// the update state then subtracts that sample once the window is full, adds
// the new one and writes it to the delay line. An item that produces a
// response then runs the restoring divider, one quotient bit per cycle over
// the SAMPLE_WIDTH + clog2(WINDOW_MAX) + 1 bit sum, and the done state loads
// the output register with the signed average once that register is free,
// so a finished average can wait for the sink while the next item is taken.
// ----------------------------------------------------------------------------
module boxcar_moving_average_core #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   bma_req_if.sink   req_chan,
   bma_rsp_if.source rsp_chan,
   bma_csr_if.sink   csr_chan
);

   localparam int WL_W   = bma_pkg::WINDOW_LENGTH_WIDTH;
   // pointer into the delay line
   localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   // effective length and fill count: must hold WINDOW_MAX and the raw register
   localparam int LEN_W  = ($clog2(WINDOW_MAX + 1) > WL_W) ? $clog2(WINDOW_MAX + 1) : WL_W;
   // exact window sum
   localparam int SUM_W  = SAMPLE_WIDTH + $clog2(WINDOW_MAX) + 1;
   localparam int EXT_W  = SUM_W - SAMPLE_WIDTH;
   // wide enough for pointer plus WINDOW_MAX without overflow
   localparam int ADR_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
   localparam int CNT_W  = $clog2(SUM_W);

   bma_pkg::bma_state_type state_ff, state_in;

   logic [WL_W-1:0]                wl_ff, wl_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic [LEN_W-1:0]               fill_ff, fill_in;
   logic [PTR_W-1:0]               wp_ff, wp_in;
   logic [SAMPLE_WIDTH-1:0]        sample_ff, sample_in;
   logic                           evict_ff, evict_in;
   logic [SUM_W-1:0]               quo_ff, quo_in;
   logic [LEN_W-1:0]               rem_ff, rem_in;
   logic                           neg_ff, neg_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]        avg_ff, avg_in;

   logic [LEN_W-1:0]               eff_len;
   logic [ADR_W-1:0]               wp_ext;
   logic [ADR_W-1:0]               len_ext;
   logic [ADR_W-1:0]               old_ext;

   logic                           ram_wr_en;
   logic                           ram_rd_en;
   logic [SAMPLE_WIDTH-1:0]        ram_rd_data;

   logic [LEN_W-1:0]               fill_base;
   logic signed [SUM_W-1:0]        sum_base;
   logic signed [SUM_W-1:0]        sum_next;
   logic signed [SUM_W-1:0]        old_sext;
   logic signed [SUM_W-1:0]        new_sext;
   logic [SUM_W-1:0]               sum_mag;
   logic [LEN_W-1:0]               fill_next;
   logic [LEN_W:0]                 trial;
   logic [LEN_W:0]                 trial_diff;
   logic [SAMPLE_WIDTH-1:0]        quo_lo;

   // saturate the register at the delay-line depth
   assign eff_len = (LEN_W'(wl_ff) > LEN_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX)
                                                         : LEN_W'(wl_ff);

   // slot of the sample leaving the window: (wp - len) mod WINDOW_MAX
   assign wp_ext  = ADR_W'(wp_ff);
   assign len_ext = ADR_W'(eff_len);
   assign old_ext = (wp_ext >= len_ext) ? (wp_ext - len_ext)
                                        : (wp_ext + ADR_W'(WINDOW_MAX) - len_ext);

   bma_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (WINDOW_MAX)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (old_ext[PTR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // sum arithmetic for the update cycle
   assign old_sext = evict_ff ? $signed({{EXT_W{ram_rd_data[SAMPLE_WIDTH-1]}}, ram_rd_data})
                              : '0;
   assign new_sext = $signed({{EXT_W{sample_ff[SAMPLE_WIDTH-1]}}, sample_ff});
   assign sum_next = sum_ff - old_sext + new_sext;
   assign sum_mag  = sum_next[SUM_W-1] ? (~sum_next + 1'b1) : sum_next;
   assign fill_next = evict_ff ? eff_len : (fill_ff + 1'b1);

   // one restoring-division step
   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_diff = trial - {1'b0, eff_len};
   assign quo_lo     = quo_ff[SAMPLE_WIDTH-1:0];

   assign fill_base = req_chan.series_start ? '0 : fill_ff;
   assign sum_base  = req_chan.series_start ? '0 : sum_ff;

   assign req_chan.ready  = (state_ff == bma_pkg::BMA_IDLE);
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.average = avg_ff;

   always_comb begin
      state_in     = state_ff;
      wl_in        = wl_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      wp_in        = wp_ff;
      sample_in    = sample_ff;
      evict_in     = evict_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         bma_pkg::BMA_IDLE: begin
            if (req_chan.valid) begin
               // series start clears before the sample is taken
               sum_in  = sum_base;
               fill_in = fill_base;
               if (eff_len != '0) begin
                  sample_in = req_chan.sample;
                  evict_in  = (fill_base >= eff_len);
                  ram_rd_en = (fill_base >= eff_len);
                  state_in  = bma_pkg::BMA_UPDATE;
               end
            end
         end
         bma_pkg::BMA_UPDATE: begin
            // drop the oldest sample, add the new one, advance the pointer
            sum_in    = sum_next;
            fill_in   = fill_next;
            ram_wr_en = 1'b1;
            wp_in     = (wp_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : (wp_ff + 1'b1);
            if (fill_next == eff_len) begin
               quo_in   = sum_mag;
               neg_in   = sum_next[SUM_W-1];
               rem_in   = '0;
               cnt_in   = '0;
               state_in = bma_pkg::BMA_DIVIDE;
            end else begin
               state_in = bma_pkg::BMA_IDLE;
            end
         end
         bma_pkg::BMA_DIVIDE: begin
            if (trial >= {1'b0, eff_len}) begin
               rem_in = trial_diff[LEN_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[LEN_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               state_in = bma_pkg::BMA_DONE;
            end
         end
         bma_pkg::BMA_DONE: begin
            // hold until the output register is free, then apply the sign
            if (!rsp_valid_ff || rsp_chan.ready) begin
               avg_in       = neg_ff ? (~quo_lo + 1'b1) : quo_lo;
               rsp_valid_in = 1'b1;
               state_in     = bma_pkg::BMA_IDLE;
            end
         end
      endcase

      // a register write restarts the series
      if (csr_chan.valid) begin
         wl_in   = csr_chan.data;
         sum_in  = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bma_pkg::BMA_IDLE;
         wl_ff        <= bma_pkg::WINDOW_LENGTH_RESET;
         sum_ff       <= '0;
         fill_ff      <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      evict_ff  <= evict_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      avg_ff    <= avg_in;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_len)
      else $error("fill count above the effective window length");

   a_ptr_bound : assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PTR_W'(WINDOW_MAX - 1))
      else $error("write pointer beyond the delay line");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bma_pkg::BMA_DIVIDE) |-> (rem_ff < eff_len))
      else $error("divider remainder not below the divisor");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bma_pkg::BMA_DONE))
      else $error("response raised outside the output load cycle");

endmodule
